FILE: rtl/iptcp_pkg.sv
// iptcp_pkg: types, constants and helpers shared by the ipv4/tcp header parser
// field record layout, option walk phases and record queue sizing
// no dependencies
`timescale 1ns / 1ps

package iptcp_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [6:0] IP_FIXED_BYTES  = 7'd20;
  localparam logic [6:0] TCP_FIXED_BYTES = 7'd20;
  localparam logic [3:0] MIN_HDR_WORDS   = 4'd5;

  typedef enum logic [4:0] {
    FID_VERSION      = 5'd0,
    FID_IP_HDR_BYTES = 5'd1,
    FID_DSCP         = 5'd2,
    FID_ECN          = 5'd3,
    FID_TOTAL_LEN    = 5'd4,
    FID_IDENT        = 5'd5,
    FID_IP_FLAGS     = 5'd6,
    FID_FRAG_OFF     = 5'd7,
    FID_TTL          = 5'd8,
    FID_PROTO        = 5'd9,
    FID_IP_CSUM      = 5'd10,
    FID_SRC_IP       = 5'd11,
    FID_DST_IP       = 5'd12,
    FID_SRC_PORT     = 5'd13,
    FID_DST_PORT     = 5'd14,
    FID_SEQ          = 5'd15,
    FID_ACK          = 5'd16,
    FID_DATA_OFF     = 5'd17,
    FID_NS           = 5'd18,
    FID_TCP_FLAGS    = 5'd19,
    FID_WINDOW       = 5'd20,
    FID_TCP_CSUM     = 5'd21,
    FID_URGENT       = 5'd22,
    FID_OPT_KIND     = 5'd23,
    FID_OPT_LEN      = 5'd24,
    FID_OPT_DATA     = 5'd25,
    FID_MALFORMED    = 5'd26
  } field_id_t;

  typedef enum logic [1:0] {
    OPH_KIND = 2'd0,
    OPH_LEN  = 2'd1,
    OPH_DATA = 2'd2
  } opt_phase_t;

  typedef struct packed {
    logic [4:0]  field_id;
    logic [31:0] field_value;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } rec_pair_t;

  function automatic rec_t mk_rec(field_id_t id, logic [31:0] value);
    rec_t r;
    r.field_id    = id;
    r.field_value = value;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic logic [3:0] fix_words(logic [3:0] w);
    return (w < MIN_HDR_WORDS) ? MIN_HDR_WORDS : w;
  endfunction

endpackage

FILE: rtl/iptcp_in_if.sv
// iptcp_in_if: byte channel into the header parser, valid/ready handshake
// depends on nothing
`timescale 1ns / 1ps

interface iptcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

FILE: rtl/iptcp_out_if.sv
// iptcp_out_if: field record channel out of the header parser, valid/ready handshake
// depends on nothing
`timescale 1ns / 1ps

interface iptcp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_id;
  logic [31:0] field_value;
  logic        last;

  modport source (output valid, output field_id, output field_value, output last,
                  input ready);
  modport sink   (input valid, input field_id, input field_value, input last,
                  output ready);
endinterface

FILE: rtl/iptcp_parse.sv
// iptcp_parse: parse state and combinational decode of one packet byte into 0..2 records
// depends on iptcp_pkg
`timescale 1ns / 1ps

module iptcp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           data_byte,
  input  logic                 first,
  output iptcp_pkg::rec_pair_t pair
);

  logic [6:0]            pos_r, pos_nxt;
  logic [3:0]            ihl_r, ihl_nxt;
  logic [3:0]            doff_r, doff_nxt;
  logic [31:0]           acc_r, acc_nxt;
  iptcp_pkg::opt_phase_t phase_r, phase_nxt;
  logic [7:0]            left_r, left_nxt;
  logic                  done_r, done_nxt;

  logic                  active;
  logic [6:0]            pos;
  logic [3:0]            ihl_w;
  logic [3:0]            doff_raw;
  iptcp_pkg::opt_phase_t phase;
  logic [7:0]            left;
  logic [31:0]           acc;
  logic [6:0]            iplen;
  logic                  in_ip, in_tcp, tcp_fixed, in_opt;
  logic [6:0]            t;
  logic [3:0]            ihl_fixed;
  logic [3:0]            doff_cur;
  logic [7:0]            t_plus;
  logic [7:0]            hdr_len;
  logic                  end_hit;
  logic                  bad_len;
  logic [7:0]            left_len;
  logic [7:0]            left_dec;

  // effective state: a first beat restarts from the cleared state
  assign active   = first || !done_r;
  assign pos      = first ? 7'd0 : pos_r;
  assign ihl_w    = first ? iptcp_pkg::MIN_HDR_WORDS : ihl_r;
  assign doff_raw = first ? iptcp_pkg::MIN_HDR_WORDS : doff_r;
  assign phase    = first ? iptcp_pkg::OPH_KIND : phase_r;
  assign left     = first ? 8'd0 : left_r;
  assign acc      = {(first ? 24'd0 : acc_r[23:0]), data_byte};

  assign iplen     = {1'b0, ihl_w, 2'b00};
  assign in_ip     = pos < iptcp_pkg::IP_FIXED_BYTES;
  assign in_tcp    = !in_ip && (pos >= iplen);
  assign t         = pos - iplen;
  assign tcp_fixed = in_tcp && (t < iptcp_pkg::TCP_FIXED_BYTES);
  assign in_opt    = in_tcp && !tcp_fixed;
  assign ihl_fixed = iptcp_pkg::fix_words(data_byte[3:0]);

  assign doff_cur = (tcp_fixed && t[4:0] == 5'd12) ? data_byte[7:4] : doff_raw;
  assign t_plus   = {1'b0, t} + 8'd1;
  assign hdr_len  = {2'b00, iptcp_pkg::fix_words(doff_cur), 2'b00};
  assign end_hit  = in_tcp && (t_plus >= hdr_len);
  assign bad_len  = in_opt && (phase == iptcp_pkg::OPH_LEN) && (data_byte < 8'd2);
  assign left_len = data_byte - 8'd2;
  assign left_dec = left - 8'd1;

  // record decode
  always_comb begin
    pair = '0;
    if (fire && active) begin
      if (in_ip) begin
        case (pos[4:0])
          5'd0: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_VERSION, {28'd0, data_byte[7:4]});
            pair.rec1 = iptcp_pkg::mk_rec(iptcp_pkg::FID_IP_HDR_BYTES,
                                          {26'd0, ihl_fixed, 2'b00});
            pair.cnt  = 2'd2;
          end
          5'd1: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_DSCP, {26'd0, data_byte[7:2]});
            pair.rec1 = iptcp_pkg::mk_rec(iptcp_pkg::FID_ECN, {30'd0, data_byte[1:0]});
            pair.cnt  = 2'd2;
          end
          5'd3: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_TOTAL_LEN, {16'd0, acc[15:0]});
            pair.cnt  = 2'd1;
          end
          5'd5: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_IDENT, {16'd0, acc[15:0]});
            pair.cnt  = 2'd1;
          end
          5'd6: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_IP_FLAGS, {29'd0, data_byte[7:5]});
            pair.cnt  = 2'd1;
          end
          5'd7: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_FRAG_OFF, {19'd0, acc[12:0]});
            pair.cnt  = 2'd1;
          end
          5'd8: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_TTL, {24'd0, data_byte});
            pair.cnt  = 2'd1;
          end
          5'd9: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_PROTO, {24'd0, data_byte});
            pair.cnt  = 2'd1;
          end
          5'd11: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_IP_CSUM, {16'd0, acc[15:0]});
            pair.cnt  = 2'd1;
          end
          5'd15: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_SRC_IP, acc);
            pair.cnt  = 2'd1;
          end
          5'd19: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_DST_IP, acc);
            pair.cnt  = 2'd1;
          end
          default: begin
          end
        endcase
      end else if (tcp_fixed) begin
        case (t[4:0])
          5'd1: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_SRC_PORT, {16'd0, acc[15:0]});
            pair.cnt  = 2'd1;
          end
          5'd3: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_DST_PORT, {16'd0, acc[15:0]});
            pair.cnt  = 2'd1;
          end
          5'd7: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_SEQ, acc);
            pair.cnt  = 2'd1;
          end
          5'd11: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_ACK, acc);
            pair.cnt  = 2'd1;
          end
          5'd12: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_DATA_OFF, {28'd0, data_byte[7:4]});
            pair.rec1 = iptcp_pkg::mk_rec(iptcp_pkg::FID_NS, {31'd0, data_byte[0]});
            pair.cnt  = 2'd2;
          end
          5'd13: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_TCP_FLAGS, {24'd0, data_byte});
            pair.cnt  = 2'd1;
          end
          5'd15: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_WINDOW, {16'd0, acc[15:0]});
            pair.cnt  = 2'd1;
          end
          5'd17: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_TCP_CSUM, {16'd0, acc[15:0]});
            pair.cnt  = 2'd1;
          end
          5'd19: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_URGENT, {16'd0, acc[15:0]});
            pair.cnt  = 2'd1;
          end
          default: begin
          end
        endcase
      end else if (in_opt) begin
        case (phase)
          iptcp_pkg::OPH_LEN: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_OPT_LEN, {24'd0, data_byte});
            pair.rec1 = iptcp_pkg::mk_rec(iptcp_pkg::FID_MALFORMED, {24'd0, data_byte});
            pair.cnt  = bad_len ? 2'd2 : 2'd1;
          end
          iptcp_pkg::OPH_DATA: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_OPT_DATA, {24'd0, data_byte});
            pair.cnt  = 2'd1;
          end
          default: begin
            pair.rec0 = iptcp_pkg::mk_rec(iptcp_pkg::FID_OPT_KIND, {24'd0, data_byte});
            pair.cnt  = 2'd1;
          end
        endcase
      end
      if (pair.cnt == 2'd1) begin
        pair.rec0.last = 1'b1;
      end
      if (pair.cnt == 2'd2) begin
        pair.rec1.last = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    pos_nxt   = pos_r;
    ihl_nxt   = ihl_r;
    doff_nxt  = doff_r;
    acc_nxt   = acc_r;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    done_nxt  = done_r;
    if (fire && active) begin
      done_nxt  = end_hit || bad_len;
      pos_nxt   = (end_hit || bad_len) ? pos : pos + 7'd1;
      ihl_nxt   = (in_ip && pos[4:0] == 5'd0) ? ihl_fixed : ihl_w;
      doff_nxt  = doff_cur;
      acc_nxt   = acc;
      phase_nxt = phase;
      left_nxt  = left;
      if (in_opt) begin
        case (phase)
          iptcp_pkg::OPH_LEN: begin
            if (bad_len) begin
              phase_nxt = iptcp_pkg::OPH_KIND;
            end else begin
              left_nxt  = left_len;
              phase_nxt = (left_len != 8'd0) ? iptcp_pkg::OPH_DATA : iptcp_pkg::OPH_KIND;
            end
          end
          iptcp_pkg::OPH_DATA: begin
            left_nxt = left_dec;
            if (left_dec == 8'd0) begin
              phase_nxt = iptcp_pkg::OPH_KIND;
            end
          end
          default: begin
            phase_nxt = (data_byte <= 8'd1) ? iptcp_pkg::OPH_KIND : iptcp_pkg::OPH_LEN;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 7'd0;
      ihl_r   <= iptcp_pkg::MIN_HDR_WORDS;
      doff_r  <= iptcp_pkg::MIN_HDR_WORDS;
      acc_r   <= 32'd0;
      phase_r <= iptcp_pkg::OPH_KIND;
      left_r  <= 8'd0;
      done_r  <= 1'b1;
    end else begin
      pos_r   <= pos_nxt;
      ihl_r   <= ihl_nxt;
      doff_r  <= doff_nxt;
      acc_r   <= acc_nxt;
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

FILE: rtl/iptcp_rec_fifo.sv
// iptcp_rec_fifo: small record queue, takes up to two records per cycle, gives one
// depends on iptcp_pkg
`timescale 1ns / 1ps

module iptcp_rec_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iptcp_pkg::rec_pair_t push,
  input  logic                 pop_ready,
  output iptcp_pkg::rec_t      head,
  output logic                 head_valid,
  output logic                 room
);

  iptcp_pkg::rec_t                  mem [iptcp_pkg::FIFO_DEPTH];
  logic [iptcp_pkg::FIFO_AW-1:0]    wp_r, wp_nxt;
  logic [iptcp_pkg::FIFO_AW-1:0]    rp_r, rp_nxt;
  logic [iptcp_pkg::FIFO_CW-1:0]    cnt_r, cnt_nxt;
  logic [iptcp_pkg::FIFO_AW-1:0]    wp_p1;
  logic                             pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem[rp_r];
  assign pop        = head_valid && pop_ready;
  // room for a full pair
  assign room       = (cnt_r <= iptcp_pkg::FIFO_CW'(iptcp_pkg::FIFO_DEPTH - 2));
  assign wp_p1      = wp_r + 1'b1;

  always_comb begin
    wp_nxt  = wp_r + iptcp_pkg::FIFO_AW'(push.cnt);
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + iptcp_pkg::FIFO_CW'(push.cnt) - iptcp_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp_r] <= push.rec0;
    end
    if (push.cnt == 2'd2) begin
      mem[wp_p1] <= push.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/ipv4_tcp_header_parser_unit.sv
// ipv4_tcp_header_parser_unit: top level of the ipv4/tcp header field parser
// depends on iptcp_pkg, iptcp_in_if, iptcp_out_if, iptcp_parse, iptcp_rec_fifo
//
// usage:
//   in_ch takes one packet byte per beat in network order; first marks byte 0
//   of a packet and restarts parsing. bytes after the tcp header end, or
//   before any first, make no records.
//   out_ch gives one field record per beat (field_id, field_value, last);
//   last marks the final record made by a byte. a byte makes 0, 1 or 2 records.
//   a byte passes the input register, then its records pass the record queue,
//   before they show on out_ch.
//   throughput: one byte per cycle while out_ch takes records and the queue has room;
//   the record pairs of bytes 0 and 1 leave three records in the four-entry queue,
//   which stalls byte 2 in the input register and holds in_ch off before byte 3.
//   in_ch.ready is high while the input register is empty or the queue has
//   room for two records.
//   reset: synchronous rst_n clears the queue and input register; the parser
//   sits idle until a first beat.
//   a stalled out_ch holds its record; once the queue lacks room and the input register holds a byte, in_ch stalls.
`timescale 1ns / 1ps

module ipv4_tcp_header_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  iptcp_in_if.sink    in_ch,
  iptcp_out_if.source out_ch
);

  logic                 in_valid_r, in_valid_nxt;
  logic [7:0]           in_byte_r;
  logic                 in_first_r;
  logic                 room;
  logic                 stage_fire;
  logic                 in_take;
  iptcp_pkg::rec_pair_t pair;
  iptcp_pkg::rec_t      head;
  logic                 head_valid;

  assign stage_fire   = in_valid_r && room;
  assign in_ch.ready  = !in_valid_r || room;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign in_valid_nxt = in_take || (in_valid_r && !room);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r  <= in_ch.data_byte;
      in_first_r <= in_ch.first;
    end
  end

  iptcp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (stage_fire),
    .data_byte (in_byte_r),
    .first     (in_first_r),
    .pair      (pair)
  );

  iptcp_rec_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (pair),
    .pop_ready  (out_ch.ready),
    .head       (head),
    .head_valid (head_valid),
    .room       (room)
  );

  assign out_ch.valid       = head_valid;
  assign out_ch.field_id    = head.field_id;
  assign out_ch.field_value = head.field_value;
  assign out_ch.last        = head.last;

  a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (pair.cnt != 2'd0) |-> stage_fire)
    else $error("records pushed without a byte in the stage");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pair.cnt == 2'd2) |-> (pair.rec1.last && !pair.rec0.last))
    else $error("last marker misplaced on a record pair");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !room) |=> (in_valid_r && $stable(in_byte_r) && $stable(in_first_r)))
    else $error("stalled byte lost from the input register");

endmodule

FILE: tb/sv/tb.sv
// tb: self-checking bench for ipv4_tcp_header_parser_unit, packet bytes in, field records out
// keeps its own field decoder and compares every record; random gaps on both channels
// depends on iptcp_pkg, iptcp_in_if, iptcp_out_if and the parser rtl
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_BYTES = 2000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [7:0]  OPT_END      = 8'd0;
  localparam logic [7:0]  OPT_NOP      = 8'd1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  iptcp_in_if  in_ch ();
  iptcp_out_if out_ch ();

  ipv4_tcp_header_parser_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // decoder state
  logic [6:0]            byte_idx  = '0;
  logic [3:0]            ip_words  = 4'd5;
  logic [3:0]            tcp_doff  = 4'd5;
  logic [31:0]           shift_acc = '0;
  iptcp_pkg::opt_phase_t opt_phase = iptcp_pkg::OPH_KIND;
  logic [7:0]            opt_left  = '0;
  logic                  hdr_done  = 1'b1;

  iptcp_pkg::rec_t pending_fields[$];
  int unsigned parsed_bytes  = 0;
  bit          failed        = 1'b0;
  bit          quiet         = 1'b0;
  int unsigned hold_seq      = 0;
  int unsigned cycle_count   = 0;

  function automatic int unsigned gap_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_field(iptcp_pkg::field_id_t id, logic [31:0] value);
    iptcp_pkg::rec_t r;
    r.field_id    = id;
    r.field_value = value;
    r.last        = 1'b0;
    pending_fields.push_back(r);
  endfunction

  // returns 1 when the byte is parsed, 0 when the decoder ignores it
  function automatic bit decode_byte(logic [7:0] b, logic frst);
    logic [6:0]  pos;
    logic [6:0]  ip_len;
    logic [6:0]  t;
    logic [3:0]  w;
    logic [3:0]  d;
    int unsigned before_cnt;
    before_cnt = pending_fields.size();
    if (frst) begin
      byte_idx  = '0;
      ip_words  = iptcp_pkg::MIN_HDR_WORDS;
      tcp_doff  = iptcp_pkg::MIN_HDR_WORDS;
      shift_acc = '0;
      opt_phase = iptcp_pkg::OPH_KIND;
      opt_left  = '0;
      hdr_done  = 1'b0;
    end else if (hdr_done) begin
      return 1'b0;
    end
    pos       = byte_idx;
    shift_acc = {shift_acc[23:0], b};
    ip_len    = {1'b0, ip_words, 2'b00};
    if (pos < iptcp_pkg::IP_FIXED_BYTES) begin
      case (pos)
        7'd0: begin
          w = (b[3:0] < iptcp_pkg::MIN_HDR_WORDS) ? iptcp_pkg::MIN_HDR_WORDS : b[3:0];
          ip_words = w;
          push_field(iptcp_pkg::FID_VERSION, 32'(b[7:4]));
          push_field(iptcp_pkg::FID_IP_HDR_BYTES, 32'({w, 2'b00}));
        end
        7'd1: begin
          push_field(iptcp_pkg::FID_DSCP, 32'(b[7:2]));
          push_field(iptcp_pkg::FID_ECN, 32'(b[1:0]));
        end
        7'd3:  push_field(iptcp_pkg::FID_TOTAL_LEN, 32'(shift_acc[15:0]));
        7'd5:  push_field(iptcp_pkg::FID_IDENT, 32'(shift_acc[15:0]));
        7'd6:  push_field(iptcp_pkg::FID_IP_FLAGS, 32'(b[7:5]));
        7'd7:  push_field(iptcp_pkg::FID_FRAG_OFF, 32'(shift_acc[12:0]));
        7'd8:  push_field(iptcp_pkg::FID_TTL, 32'(b));
        7'd9:  push_field(iptcp_pkg::FID_PROTO, 32'(b));
        7'd11: push_field(iptcp_pkg::FID_IP_CSUM, 32'(shift_acc[15:0]));
        7'd15: push_field(iptcp_pkg::FID_SRC_IP, shift_acc);
        7'd19: push_field(iptcp_pkg::FID_DST_IP, shift_acc);
        default: ;
      endcase
    end else if (pos >= ip_len) begin
      t = pos - ip_len;
      if (t < iptcp_pkg::TCP_FIXED_BYTES) begin
        case (t)
          7'd1:  push_field(iptcp_pkg::FID_SRC_PORT, 32'(shift_acc[15:0]));
          7'd3:  push_field(iptcp_pkg::FID_DST_PORT, 32'(shift_acc[15:0]));
          7'd7:  push_field(iptcp_pkg::FID_SEQ, shift_acc);
          7'd11: push_field(iptcp_pkg::FID_ACK, shift_acc);
          7'd12: begin
            tcp_doff = b[7:4];
            push_field(iptcp_pkg::FID_DATA_OFF, 32'(b[7:4]));
            push_field(iptcp_pkg::FID_NS, 32'(b[0]));
          end
          7'd13: push_field(iptcp_pkg::FID_TCP_FLAGS, 32'(b));
          7'd15: push_field(iptcp_pkg::FID_WINDOW, 32'(shift_acc[15:0]));
          7'd17: push_field(iptcp_pkg::FID_TCP_CSUM, 32'(shift_acc[15:0]));
          7'd19: push_field(iptcp_pkg::FID_URGENT, 32'(shift_acc[15:0]));
          default: ;
        endcase
      end else begin
        case (opt_phase)
          iptcp_pkg::OPH_LEN: begin
            push_field(iptcp_pkg::FID_OPT_LEN, 32'(b));
            if (b < 8'd2) begin
              push_field(iptcp_pkg::FID_MALFORMED, 32'(b));
              hdr_done  = 1'b1;
              opt_phase = iptcp_pkg::OPH_KIND;
            end else begin
              opt_left  = b - 8'd2;
              opt_phase = (opt_left != 0) ? iptcp_pkg::OPH_DATA : iptcp_pkg::OPH_KIND;
            end
          end
          iptcp_pkg::OPH_DATA: begin
            push_field(iptcp_pkg::FID_OPT_DATA, 32'(b));
            opt_left = opt_left - 8'd1;
            if (opt_left == 0) opt_phase = iptcp_pkg::OPH_KIND;
          end
          default: begin
            push_field(iptcp_pkg::FID_OPT_KIND, 32'(b));
            opt_phase = (b <= OPT_NOP) ? iptcp_pkg::OPH_KIND : iptcp_pkg::OPH_LEN;
          end
        endcase
      end
      d = (tcp_doff < iptcp_pkg::MIN_HDR_WORDS) ? iptcp_pkg::MIN_HDR_WORDS : tcp_doff;
      if (int'(t) + 1 >= int'(d) * 4) hdr_done = 1'b1;
    end
    if (!hdr_done) byte_idx = pos + 7'd1;
    if (pending_fields.size() > before_cnt)
      pending_fields[pending_fields.size() - 1].last = 1'b1;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic frst);
    int unsigned g;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.first     <= frst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (decode_byte(b, frst)) parsed_bytes++;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_packet(ref logic [7:0] pkt[$]);
    foreach (pkt[i]) send_byte(pkt[i], i == 0);
  endtask

  // ip and fixed tcp header; fill < 0 gives random bytes
  function automatic void build_headers(ref logic [7:0] pkt[$], input logic [3:0] ihl,
                                        input logic [3:0] doff, input int fill);
    int unsigned ip_bytes;
    pkt.delete();
    ip_bytes = (ihl < iptcp_pkg::MIN_HDR_WORDS) ? 20 : int'(ihl) * 4;
    repeat (ip_bytes + 20) pkt.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    pkt[0] = {pkt[0][7:4], ihl};
    pkt[ip_bytes + 12] = {doff, pkt[ip_bytes + 12][3:0]};
  endfunction

  function automatic void add_random_options(ref logic [7:0] pkt[$], input int room);
    int start;
    int unsigned sel;
    int unsigned len;
    start = pkt.size();
    while (pkt.size() - start < room) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        pkt.push_back(OPT_END);
      end else if (sel < 30) begin
        pkt.push_back(OPT_NOP);
      end else if (sel < 36) begin
        pkt.push_back(8'($urandom_range(2, 255)));
        pkt.push_back(8'($urandom_range(0, 1)));
      end else begin
        pkt.push_back(8'($urandom_range(2, 255)));
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(2, 255) : $urandom_range(2, 10);
        pkt.push_back(8'(len));
        repeat (len - 2) pkt.push_back(8'($urandom));
      end
    end
  endfunction

  task automatic check_record();
    iptcp_pkg::rec_t want;
    if (pending_fields.size() == 0) begin
      $error("record with none expected: field_id %0d field_value %0h",
             out_ch.field_id, out_ch.field_value);
      failed = 1'b1;
      return;
    end
    want = pending_fields.pop_front();
    if (out_ch.field_id !== want.field_id) begin
      $error("field_id: expected %0d, got %0d", want.field_id, out_ch.field_id);
      failed = 1'b1;
    end
    if (out_ch.field_value !== want.field_value) begin
      $error("field_value: expected %0h, got %0h", want.field_value, out_ch.field_value);
      failed = 1'b1;
    end
    if (out_ch.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, out_ch.last);
      failed = 1'b1;
    end
  endtask

  // record sink with random stalls and an on-request long hold
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_record();
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left = gap_len();
      out_ch.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_idle_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h45, 1'b0);
  endtask

  // ihl and data offset below five, all-ones and all-zeros fields, largest ihl
  task automatic test_short_headers();
    logic [7:0] pkt[$];
    build_headers(pkt, 4'd0, 4'd0, 8'hFF);
    pkt.push_back(8'hAA);
    send_packet(pkt);
    build_headers(pkt, 4'd15, 4'd5, 8'h00);
    send_packet(pkt);
  endtask

  // end of list, nop, zero-data option, kind in the last header byte
  task automatic test_option_walk();
    logic [7:0] pkt[$];
    build_headers(pkt, 4'd6, 4'd8, -1);
    pkt = {pkt, OPT_END, OPT_NOP, 8'd2, 8'd4, 8'h5A, 8'hA5, 8'd3, 8'd3, 8'h81,
           8'd4, 8'd2, 8'd30, 8'h11, 8'h22};
    send_packet(pkt);
  endtask

  // option data cut at header end, then lengths of one and zero
  task automatic test_bad_options();
    logic [7:0] pkt[$];
    build_headers(pkt, 4'd5, 4'd6, -1);
    pkt = {pkt, 8'd8, 8'd10, 8'h01, 8'h02, 8'h03};
    send_packet(pkt);
    build_headers(pkt, 4'd5, 4'd7, -1);
    pkt = {pkt, 8'd5, 8'd1, 8'd2, 8'd4, 8'h00, 8'h00};
    send_packet(pkt);
    build_headers(pkt, 4'd5, 4'd7, -1);
    pkt = {pkt, OPT_NOP, 8'd9, 8'd0, 8'hFF};
    send_packet(pkt);
  endtask

  // first beat in the middle of a header restarts the parse
  task automatic test_restart();
    logic [7:0] pkt[$];
    build_headers(pkt, 4'd5, 4'd5, -1);
    pkt = pkt[0:8];
    send_packet(pkt);
    build_headers(pkt, 4'd7, 4'd6, -1);
    add_random_options(pkt, 4);
    send_packet(pkt);
  endtask

  // sink holds off while bytes keep coming, so the record queue fills
  task automatic test_backpressure();
    logic [7:0] pkt[$];
    quiet = 1'b1;
    hold_seq++;
    repeat (3) begin
      build_headers(pkt, 4'd5, 4'd10, -1);
      add_random_options(pkt, 20);
      send_packet(pkt);
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_packets();
    logic [7:0]  pkt[$];
    logic [3:0]  ihl;
    logic [3:0]  doff;
    int unsigned room;
    int unsigned cut;
    int unsigned goal;
    goal = parsed_bytes + RANDOM_BYTES;
    while (parsed_bytes < goal) begin
      if ($urandom_range(0, 99) < 15) quiet = !quiet;
      ihl  = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(0, 15));
      case ($urandom_range(0, 4))
        0, 1:    doff = 4'd5;
        2, 3:    doff = 4'($urandom_range(6, 10));
        default: doff = 4'($urandom_range(0, 15));
      endcase
      build_headers(pkt, ihl, doff, -1);
      room = (doff < iptcp_pkg::MIN_HDR_WORDS) ? 0 : int'(doff) * 4 - 20;
      add_random_options(pkt, room);
      repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0);
      send_packet(pkt);
    end
    quiet = 1'b0;
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.first     <= 1'b0;
    rst_n           <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_bytes();
    test_short_headers();
    test_option_walk();
    test_bad_options();
    test_restart();
    test_backpressure();
    test_random_packets();

    in_ch.valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
